[hw/rtl/bapd_pkg.sv]
// ----------------------------------------------------------------------------
// bapd_pkg
// Shared types, sizes and palette for the bitmap/attribute pixel decoder.
// ----------------------------------------------------------------------------
package bapd_pkg;

   localparam int SCREEN_W     = 256;
   localparam int SCREEN_H     = 192;
   localparam int BITMAP_BYTES = 6144;
   localparam int ATTR_BYTES   = 768;
   localparam int STORE_BYTES  = BITMAP_BYTES + ATTR_BYTES;

   localparam int OFFSET_W   = 13;
   localparam int BITMAP_AW  = $clog2(BITMAP_BYTES);
   localparam int ATTR_AW    = $clog2(ATTR_BYTES);
   localparam int FRAME_W    = 5;
   localparam int FLASH_BIT  = 4;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_FRAME = 2'd1,
      FUNC_PIXEL = 2'd2
   } bapd_func_type;

   // control that travels with a pixel fetch while the store read is pending
   typedef struct packed {
      logic       valid;
      logic [2:0] bit_sel;
      logic       flash;
   } bapd_fetch_type;

   function automatic logic [23:0] bapd_palette(input logic [3:0] idx);
      logic [23:0] rgb;
      unique case (idx)
         4'd0:    rgb = 24'h000000;
         4'd1:    rgb = 24'h0000D7;
         4'd2:    rgb = 24'hD70000;
         4'd3:    rgb = 24'hD700D7;
         4'd4:    rgb = 24'h00D700;
         4'd5:    rgb = 24'h00D7D7;
         4'd6:    rgb = 24'hD7D700;
         4'd7:    rgb = 24'hD7D7D7;
         4'd8:    rgb = 24'h000000;
         4'd9:    rgb = 24'h0000FF;
         4'd10:   rgb = 24'hFF0000;
         4'd11:   rgb = 24'hFF00FF;
         4'd12:   rgb = 24'h00FF00;
         4'd13:   rgb = 24'h00FFFF;
         4'd14:   rgb = 24'hFFFF00;
         default: rgb = 24'hFFFFFF;
      endcase
      return rgb;
   endfunction

endpackage

[hw/rtl/bapd_store.sv]
// ----------------------------------------------------------------------------
// bapd_store
// Display store: bitmap and attribute memories, one write and one
// registered read per memory per cycle.
// ----------------------------------------------------------------------------
module bapd_store import bapd_pkg::*; (
   input  logic                 clock,
   input  logic                 wr_bitmap_en,
   input  logic                 wr_attr_en,
   input  logic [OFFSET_W-1:0]  wr_offset,
   input  logic [7:0]           wr_data,
   input  logic                 rd_en,
   input  logic [BITMAP_AW-1:0] rd_bitmap_addr,
   input  logic [ATTR_AW-1:0]   rd_attr_addr,
   output logic [7:0]           bitmap_byte,
   output logic [7:0]           attr_byte
);

   logic [7:0] bitmap_mem [BITMAP_BYTES];
   logic [7:0] attr_mem [ATTR_BYTES];
   logic [7:0] bitmap_rd_ff;
   logic [7:0] attr_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_bitmap_en) begin
         bitmap_mem[wr_offset[BITMAP_AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         bitmap_rd_ff <= bitmap_mem[rd_bitmap_addr];
      end
   end

   // attribute area starts on a 1K boundary, so the low bits index it
   always_ff @(posedge clock) begin
      if (wr_attr_en) begin
         attr_mem[wr_offset[ATTR_AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         attr_rd_ff <= attr_mem[rd_attr_addr];
      end
   end

   assign bitmap_byte = bitmap_rd_ff;
   assign attr_byte   = attr_rd_ff;

endmodule

[hw/rtl/bapd_color.sv]
// ----------------------------------------------------------------------------
// bapd_color
// Pixel color resolve (bit select, bright, flash swap, palette) and the
// result output register.
// ----------------------------------------------------------------------------
module bapd_color import bapd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  bapd_fetch_type fetch,
   input  logic [7:0]     bitmap_byte,
   input  logic [7:0]     attr_byte,
   input  logic           rsp_stall,
   output logic           advance,
   output logic           rsp_valid,
   output logic [23:0]    rsp_pixel_rgb,
   output logic [3:0]     rsp_color_index
);

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [23:0] rgb_ff;
   logic [3:0]  index_ff;
   logic [3:0]  index_in;
   logic        lit;
   logic        swap;
   logic [3:0]  ink;
   logic [3:0]  paper;

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      lit      = bitmap_byte[3'd7 - fetch.bit_sel];
      ink      = {attr_byte[6], attr_byte[2:0]};
      paper    = {attr_byte[6], attr_byte[5:3]};
      swap     = attr_byte[7] && fetch.flash;
      index_in = (lit ^ swap) ? ink : paper;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = fetch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && fetch.valid) begin
         index_ff <= index_in;
         rgb_ff   <= bapd_palette(index_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_rgb   = rgb_ff;
   assign rsp_color_index = index_ff;

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(index_ff))
      else $error("result beat lost or changed under stall");
   a_rgb_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rgb_ff == bapd_palette(index_ff))
      else $error("rgb does not match palette index");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      advance && fetch.valid |=> rsp_valid_ff)
      else $error("fetched pixel did not reach output");
`endif

endmodule

[hw/rtl/bitmap_attribute_pixel_decoder_top.sv]
// ----------------------------------------------------------------------------
// bitmap_attribute_pixel_decoder_top
// 256x192 bitmap plus attribute pixel decoder with display store and frame
// counter.
// ----------------------------------------------------------------------------
// Takes one beat per clock while input stall is low: store writes, frame
// starts and pixel requests may follow each other with no gaps. A pixel
// result, once its request is accepted, passes through the registered read
// of the bitmap and attribute memories (each read once per pixel, in
// parallel), then through the color resolve into the output register.
// Writes, frame starts, unused codes, writes past the store and requests
// with a line at or past 192 give no result. The store holds whatever was
// written; reading an unwritten byte gives an undefined color. Input stall
// rises only while a fetched pixel and a held result are both waiting on a stalled output.
module bitmap_attribute_pixel_decoder_top import bapd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic [OFFSET_W-1:0] req_store_offset,
   input  logic [7:0]          req_store_byte,
   input  logic [7:0]          req_pixel_x,
   input  logic [7:0]          req_pixel_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [23:0]         rsp_pixel_rgb,
   output logic [3:0]          rsp_color_index
);

   logic                 req_accept;
   logic                 wr_bitmap_en;
   logic                 wr_attr_en;
   logic                 frame_step;
   logic                 pixel_accept;
   logic                 advance;
   logic [FRAME_W-1:0]   frame_count_ff;
   logic [FRAME_W-1:0]   frame_count_in;
   bapd_fetch_type       fetch_ff;
   bapd_fetch_type       fetch_in;
   logic [BITMAP_AW-1:0] rd_bitmap_addr;
   logic [ATTR_AW-1:0]   rd_attr_addr;
   logic [7:0]           bitmap_byte;
   logic [7:0]           attr_byte;

   assign req_stall  = fetch_ff.valid && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      wr_bitmap_en = 1'b0;
      wr_attr_en   = 1'b0;
      frame_step   = 1'b0;
      pixel_accept = 1'b0;
      unique case (bapd_func_type'(req_func))
         FUNC_WRITE: begin
            wr_bitmap_en = req_accept && (req_store_offset < OFFSET_W'(BITMAP_BYTES));
            wr_attr_en   = req_accept && (req_store_offset >= OFFSET_W'(BITMAP_BYTES))
                           && (req_store_offset < OFFSET_W'(STORE_BYTES));
         end
         FUNC_FRAME: begin
            frame_step = req_accept;
         end
         FUNC_PIXEL: begin
            pixel_accept = req_accept && (req_pixel_y < 8'(SCREEN_H));
         end
         default: begin
         end
      endcase
   end

   // bitmap interleave: third, line in cell, character row, column
   assign rd_bitmap_addr = {req_pixel_y[7:6], req_pixel_y[2:0], req_pixel_y[5:3],
                            req_pixel_x[7:3]};
   assign rd_attr_addr   = {req_pixel_y[7:3], req_pixel_x[7:3]};

   always_comb begin
      frame_count_in = frame_count_ff;
      if (frame_step) begin
         frame_count_in = frame_count_ff + FRAME_W'(1);
      end
   end

   always_comb begin
      fetch_in = fetch_ff;
      if (pixel_accept) begin
         fetch_in.valid   = 1'b1;
         fetch_in.bit_sel = req_pixel_x[2:0];
         fetch_in.flash   = frame_count_ff[FLASH_BIT];
      end else if (advance) begin
         fetch_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         fetch_ff       <= '0;
      end else begin
         frame_count_ff <= frame_count_in;
         fetch_ff       <= fetch_in;
      end
   end

   bapd_store u_store (
      .clock          (clock),
      .wr_bitmap_en   (wr_bitmap_en),
      .wr_attr_en     (wr_attr_en),
      .wr_offset      (req_store_offset),
      .wr_data        (req_store_byte),
      .rd_en          (pixel_accept),
      .rd_bitmap_addr (rd_bitmap_addr),
      .rd_attr_addr   (rd_attr_addr),
      .bitmap_byte    (bitmap_byte),
      .attr_byte      (attr_byte)
   );

   bapd_color u_color (
      .clock           (clock),
      .reset           (reset),
      .fetch           (fetch_ff),
      .bitmap_byte     (bitmap_byte),
      .attr_byte       (attr_byte),
      .rsp_stall       (rsp_stall),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_rgb   (rsp_pixel_rgb),
      .rsp_color_index (rsp_color_index)
   );

`ifndef SYNTHESIS
   a_frame_step: assert property (@(posedge clock) disable iff (reset)
      frame_step |=> frame_count_ff == $past(frame_count_ff) + FRAME_W'(1))
      else $error("frame counter did not advance");
   a_frame_hold: assert property (@(posedge clock) disable iff (reset)
      !frame_step |=> $stable(frame_count_ff))
      else $error("frame counter moved without frame start");
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> fetch_ff.valid && rsp_valid && rsp_stall)
      else $error("input stalled without a blocked pipeline");
   a_fetch_held: assert property (@(posedge clock) disable iff (reset)
      fetch_ff.valid && !advance |=> fetch_ff.valid && $stable(fetch_ff))
      else $error("pending fetch lost while output blocked");
`endif

endmodule

[bench/tb_bitmap_attribute_pixel_decoder_top.sv]
// ----------------------------------------------------------------------------
// tb_bitmap_attribute_pixel_decoder_top
// Self-checking bench for the bitmap/attribute pixel decoder. A queue of beats
// (store writes, frame starts, pixel requests and ignored codes) feeds a
// clocked driver. A monitor predicts each accepted beat against a shadow
// display store and frame counter and checks returned pixels in order. Pixel
// requests only touch store bytes that were written before.
// ----------------------------------------------------------------------------
module tb_bitmap_attribute_pixel_decoder_top import bapd_pkg::*; ();

   localparam logic [1:0] FUNC_UNUSED    = 2'd3;
   localparam int         ATTR_FLASH     = 7;
   localparam int         ATTR_BRIGHT    = 6;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         RANDOM_BEATS   = 550;
   localparam int         PHASES         = 5;

   typedef struct {
      logic [1:0]          func;
      logic [OFFSET_W-1:0] offset;
      logic [7:0]          data;
      logic [7:0]          x;
      logic [7:0]          y;
   } video_beat_type;

   typedef struct {
      logic [23:0] rgb;
      logic [3:0]  index;
   } pixel_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func = FUNC_WRITE;
   logic [OFFSET_W-1:0] req_store_offset = '0;
   logic [7:0]          req_store_byte = '0;
   logic [7:0]          req_pixel_x = '0;
   logic [7:0]          req_pixel_y = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [23:0]         rsp_pixel_rgb;
   logic [3:0]          rsp_color_index;

   video_beat_type beat_q [$];
   pixel_type      pixel_q [$];
   bit          gen_written [STORE_BYTES];
   logic [7:0]  video_ram [STORE_BYTES];
   logic [FRAME_W-1:0] frame_ctr = '0;

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  beats_queued = 0;
   int  beats_taken = 0;
   int  live_beats = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   logic req_beat_done = 1'b0;

   bitmap_attribute_pixel_decoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_store_offset(req_store_offset),
      .req_store_byte  (req_store_byte),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_rgb   (rsp_pixel_rgb),
      .rsp_color_index (rsp_color_index)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [OFFSET_W-1:0] bitmap_offset(input logic [7:0] x,
                                                        input logic [7:0] y);
      return {y[7:6], y[2:0], y[5:3], x[7:3]};
   endfunction

   function automatic logic [OFFSET_W-1:0] attr_offset(input logic [7:0] x,
                                                      input logic [7:0] y);
      return OFFSET_W'(BITMAP_BYTES) + {3'b000, y[7:3], x[7:3]};
   endfunction

   // bit 0 blue, bit 1 red, bit 2 green; bit 3 raises the level
   function automatic logic [23:0] index_to_rgb(input logic [3:0] idx);
      logic [7:0] lvl;
      lvl = idx[3] ? 8'hFF : 8'hD7;
      return {idx[1] ? lvl : 8'h00, idx[2] ? lvl : 8'h00, idx[0] ? lvl : 8'h00};
   endfunction

   task automatic queue_beat(input logic [1:0] func, input int off, input int data,
                             input int x, input int y);
      video_beat_type b;
      b.func = func;
      b.offset = OFFSET_W'(off);
      b.data = 8'(data);
      b.x = 8'(x);
      b.y = 8'(y);
      beat_q.push_back(b);
      beats_queued++;
      if (func == FUNC_WRITE && off < STORE_BYTES) begin
         gen_written[off] = 1'b1;
         live_beats++;
      end
      if (func == FUNC_FRAME || (func == FUNC_PIXEL && y < SCREEN_H))
         live_beats++;
   endtask

   task automatic queue_write(input int off, input int data);
      queue_beat(FUNC_WRITE, off, data, $urandom_range(255), $urandom_range(255));
   endtask

   // backfill any store byte the pixel would read before requesting it
   task automatic queue_pixel(input int x, input int y);
      logic [OFFSET_W-1:0] boff;
      logic [OFFSET_W-1:0] aoff;
      boff = bitmap_offset(8'(x), 8'(y));
      aoff = attr_offset(8'(x), 8'(y));
      if (!gen_written[boff])
         queue_write(int'(boff), $urandom_range(255));
      if (!gen_written[aoff])
         queue_write(int'(aoff), $urandom_range(255));
      queue_beat(FUNC_PIXEL, $urandom_range(8191), $urandom_range(255), x, y);
   endtask

   task automatic queue_directed();
      queue_write(0, 'h80);
      queue_write(BITMAP_BYTES, 'hC5);
      queue_pixel(0, 0);
      queue_pixel(1, 0);
      queue_write(BITMAP_BYTES - 1, 'h01);
      queue_write(STORE_BYTES - 1, 'h3A);
      queue_pixel(255, 191);
      queue_pixel(248, 191);
      queue_write(STORE_BYTES, 'h00);
      queue_write('h1FFF, 'hFF);
      queue_beat(FUNC_PIXEL, 0, 'h00, 0, 192);
      queue_beat(FUNC_PIXEL, 'h1FFF, 'hFF, 255, 255);
      queue_beat(FUNC_UNUSED, 'h1FFF, 'hFF, 'hFF, 'hFF);
      queue_beat(FUNC_FRAME, 'h1FFF, 'hFF, 'hFF, 'hFF);
      queue_pixel(0, 0);
      queue_write(0, 'h00);
      queue_pixel(7, 0);
      queue_write(BITMAP_BYTES, 'h00);
      queue_pixel(0, 0);
      queue_write(BITMAP_BYTES - 1, 'hFF);
      queue_pixel(250, 191);
   endtask

   task automatic queue_random(input int count);
      int start;
      int pick;
      int col;
      int row;
      logic [7:0] x;
      logic [7:0] y;
      start = live_beats;
      while (live_beats - start < count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // one character cell: attribute, bitmap lines and pixels inside it
            col = $urandom_range(31);
            row = $urandom_range(23);
            if ($urandom_range(1))
               queue_write(int'(attr_offset(8'(col * 8), 8'(row * 8))),
                           $urandom_range(255));
            repeat ($urandom_range(4, 1)) begin
               x = 8'(col * 8 + $urandom_range(7));
               y = 8'(row * 8 + $urandom_range(7));
               if ($urandom_range(2) == 0)
                  queue_write(int'(bitmap_offset(x, y)), $urandom_range(255));
               queue_pixel(int'(x), int'(y));
            end
         end else if (pick < 58) begin
            queue_pixel($urandom_range(255), $urandom_range(SCREEN_H - 1));
         end else if (pick < 75) begin
            queue_beat(FUNC_FRAME, $urandom_range(8191), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255));
         end else if (pick < 85) begin
            queue_write($urandom_range(STORE_BYTES - 1), $urandom_range(255));
         end else if (pick < 90) begin
            queue_write($urandom_range(8191, STORE_BYTES), $urandom_range(255));
         end else if (pick < 95) begin
            queue_beat(FUNC_PIXEL, $urandom_range(8191), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255, SCREEN_H));
         end else begin
            queue_beat(FUNC_UNUSED, $urandom_range(8191), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255));
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (beats_taken != beats_queued || pixel_q.size() != 0);
   endtask

   task automatic predict_beat();
      logic [7:0] bits;
      logic [7:0] attr;
      logic [3:0] ink;
      logic [3:0] paper;
      logic [3:0] swap;
      pixel_type  px;
      case (req_func)
         FUNC_WRITE: begin
            if (req_store_offset < OFFSET_W'(STORE_BYTES))
               video_ram[req_store_offset] = req_store_byte;
         end
         FUNC_FRAME: begin
            frame_ctr = frame_ctr + FRAME_W'(1);
         end
         FUNC_PIXEL: begin
            if (req_pixel_y < 8'(SCREEN_H)) begin
               bits = video_ram[bitmap_offset(req_pixel_x, req_pixel_y)];
               attr = video_ram[attr_offset(req_pixel_x, req_pixel_y)];
               ink = {attr[ATTR_BRIGHT], attr[2:0]};
               paper = {attr[ATTR_BRIGHT], attr[5:3]};
               if (attr[ATTR_FLASH] && frame_ctr[FLASH_BIT]) begin
                  swap = ink;
                  ink = paper;
                  paper = swap;
               end
               px.index = bits[3'd7 - req_pixel_x[2:0]] ? ink : paper;
               px.rgb = index_to_rgb(px.index);
               pixel_q.push_back(px);
            end
         end
         default: ;
      endcase
   endtask

   always @(negedge clock) begin : drive
      video_beat_type b;
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
      if (reset || (req_valid && !req_beat_done)) begin
         // hold the stalled beat
      end else if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         b = beat_q.pop_front();
         req_valid <= 1'b1;
         req_func <= b.func;
         req_store_offset <= b.offset;
         req_store_byte <= b.data;
         req_pixel_x <= b.x;
         req_pixel_y <= b.y;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin : watch
      pixel_type want;
      bit        moved;
      if (!reset) begin
         moved = 1'b0;
         req_beat_done <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_beat();
            beats_taken++;
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pixel_q.size() == 0) begin
               mismatches++;
               $error("unexpected pixel beat: pixel_rgb %06h color_index %0d",
                      rsp_pixel_rgb, rsp_color_index);
            end else begin
               want = pixel_q.pop_front();
               if (rsp_pixel_rgb !== want.rgb) begin
                  mismatches++;
                  $error("pixel_rgb: expected %06h, got %06h", want.rgb, rsp_pixel_rgb);
               end
               if (rsp_color_index !== want.index) begin
                  mismatches++;
                  $error("color_index: expected %0d, got %0d", want.index,
                         rsp_color_index);
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      queue_directed();
      wait_drained();
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1:       begin send_idle_pct <= 45; stall_pct <= 0;  end
            2:       begin send_idle_pct <= 0;  stall_pct <= 45; end
            3:       begin send_idle_pct <= 29; stall_pct <= 29; end
            default: begin send_idle_pct <= 0;  stall_pct <= 0;  end
         endcase
         queue_random(RANDOM_BEATS / PHASES);
         wait_drained();
      end
      repeat (6) @(negedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
